// ===== design/tcc_pkg.sv =====
// text console cursor/scroll engine: shared types and constants
// used by the channel interfaces and the core; no dependencies
package tcc_pkg;

  localparam int ModeW    = 2;
  localparam int ConsoleW = 2;
  localparam int ByteW    = 8;
  localparam int AddrOutW = 14;

  typedef enum logic [ModeW-1:0] {
    MODE_PUT         = 2'd0,
    MODE_SCROLL_UP   = 2'd1,
    MODE_SCROLL_DOWN = 2'd2,
    MODE_SELECT      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_CELL,
    S_DISP
  } state_e;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_DISP = 1'b1;

  localparam logic [ByteW-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [ByteW-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [ByteW-1:0] CH_BLANK     = 8'd32;
  localparam logic [ByteW-1:0] ATTR_RESET   = 8'd7;

endpackage

// ===== design/tcc_in_if.sv =====
// input item channel of the text console engine
// depends on tcc_pkg for field widths
interface tcc_in_if import tcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [ConsoleW-1:0] console;
  logic [ByteW-1:0]    char_code;

  modport source (output valid, output mode, output console, output char_code, input ready);
  modport sink   (input valid, input mode, input console, input char_code, output ready);
endinterface

// ===== design/tcc_out_if.sv =====
// result channel of the text console engine: cell writes and display updates
// depends on tcc_pkg for field widths
interface tcc_out_if import tcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [AddrOutW-1:0] vmem_addr;
  logic [ByteW-1:0]    vmem_char;
  logic [ByteW-1:0]    vmem_attr;
  logic [AddrOutW-1:0] cursor_pos;
  logic [AddrOutW-1:0] start_addr;
  logic                last;

  modport source (output valid, output kind, output vmem_addr, output vmem_char,
                  output vmem_attr, output cursor_pos, output start_addr,
                  output last, input ready);
  modport sink   (input valid, input kind, input vmem_addr, input vmem_char,
                  input vmem_attr, input cursor_pos, input start_addr,
                  input last, output ready);
endinterface

// ===== design/tcc_cfg_if.sv =====
// attribute register write channel of the text console engine
// depends on tcc_pkg for the data width
interface tcc_cfg_if import tcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/text_console_cursor_scroll_core.sv =====
// multi-console text engine: cursor, column and view per console, one adder/compare
// stepping the auto-scroll a line per cycle; depends on tcc_pkg and the tcc_*_if channels
// sequence: accept, execute, then the scroll state, which moves the view a line at a time,
//   then the result transfers, each held by any receiver stall; a put on the visible
//   console that writes a cell sends a cell write, then a display update
// throughput: one item at a time, ready again in the cycle after the last transfer
// reset: cursors and views at their region starts, console 0 visible, attribute 7
module text_console_cursor_scroll_core import tcc_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int CONSOLES    = 4,
  parameter int VIDEO_WORDS = 16384
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcc_in_if.sink     in_i,
  tcc_out_if.source  out_o,
  tcc_cfg_if.sink    cfg_i
);

  localparam int VidW        = $clog2(VIDEO_WORDS) + 1;
  localparam int AW          = (VidW > AddrOutW) ? VidW : AddrOutW;
  localparam int CW          = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
  localparam int IW          = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
  localparam int Screen      = SCREEN_COLS * SCREEN_ROWS;
  localparam int RegionSize  = VIDEO_WORDS / CONSOLES;
  localparam int RegionLimit = RegionSize / SCREEN_COLS * SCREEN_COLS;

  state_e state_q, state_d;

  logic [AW-1:0] cur_mem_q  [CONSOLES];
  logic [AW-1:0] view_mem_q [CONSOLES];
  logic [CW-1:0] col_mem_q  [CONSOLES];
  logic [IW-1:0] vis_q;
  logic [ByteW-1:0] attr_q;

  mode_e            mode_q;
  logic [IW-1:0]    con_q;
  logic [ByteW-1:0] char_q;
  logic [AW-1:0]    cur_q, cur_d;
  logic [AW-1:0]    view_q, view_d;
  logic [CW-1:0]    col_q, col_d;
  logic             cell_pend_q, cell_pend_d;
  logic [AW-1:0]    cell_addr_q, cell_addr_d;
  logic [ByteW-1:0] cell_char_q, cell_char_d;
  logic             disp_q;

  logic [AW-1:0] base_w, end_w, scr_sum_w, nl_next_w;
  logic          in_fire, out_fire, con_ok, step_en, disp_w, wb_en;
  logic [IW-1:0] in_con_w;

  assign in_fire   = in_i.valid & in_i.ready;
  assign out_fire  = out_o.valid & out_o.ready;
  assign con_ok    = int'(in_i.console) < CONSOLES;
  assign in_con_w  = IW'(in_i.console);
  assign base_w    = AW'(AW'(con_q) * AW'(RegionSize));
  assign end_w     = base_w + AW'(RegionLimit);
  // shared unit: view + one screen, compared against cursor and region end
  assign scr_sum_w = view_q + AW'(Screen);
  assign nl_next_w = cur_q + AW'(SCREEN_COLS);
  assign step_en   = (mode_q == MODE_PUT) && (cur_q >= scr_sum_w) && (scr_sum_w < end_w);
  assign disp_w    = (con_q == vis_q);
  assign wb_en     = (state_q == S_SCROLL) && !step_en;
  assign cfg_i.ready = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && con_ok) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_SCROLL;
      S_SCROLL: begin
        priority if (step_en) state_d = S_SCROLL;
        else if (cell_pend_q) state_d = S_CELL;
        else if (disp_w)      state_d = S_DISP;
        else                  state_d = S_IDLE;
      end
      S_CELL: begin
        if (out_fire) state_d = disp_q ? S_DISP : S_IDLE;
      end
      S_DISP: begin
        if (out_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready       = 1'b0;
    out_o.valid      = 1'b0;
    out_o.kind       = KIND_CELL;
    out_o.vmem_addr  = '0;
    out_o.vmem_char  = '0;
    out_o.vmem_attr  = '0;
    out_o.cursor_pos = '0;
    out_o.start_addr = '0;
    out_o.last       = 1'b0;
    unique case (state_q)
      S_IDLE: in_i.ready = 1'b1;
      S_CELL: begin
        out_o.valid     = 1'b1;
        out_o.kind      = KIND_CELL;
        out_o.vmem_addr = cell_addr_q[AddrOutW-1:0];
        out_o.vmem_char = cell_char_q;
        out_o.vmem_attr = attr_q;
        out_o.last      = !disp_q;
      end
      S_DISP: begin
        out_o.valid      = 1'b1;
        out_o.kind       = KIND_DISP;
        out_o.cursor_pos = cur_q[AddrOutW-1:0];
        out_o.start_addr = view_q[AddrOutW-1:0];
        out_o.last       = 1'b1;
      end
      default: ;
    endcase
  end

  // working copy of the addressed console
  always_comb begin
    cur_d       = cur_q;
    view_d      = view_q;
    col_d       = col_q;
    cell_pend_d = cell_pend_q;
    cell_addr_d = cell_addr_q;
    cell_char_d = cell_char_q;
    unique case (state_q)
      S_IDLE: begin
        cur_d       = cur_mem_q[in_con_w];
        view_d      = view_mem_q[in_con_w];
        col_d       = col_mem_q[in_con_w];
        cell_pend_d = 1'b0;
      end
      S_EXEC: begin
        unique case (mode_q)
          MODE_PUT: begin
            priority if (char_q == CH_NEWLINE) begin
              if (nl_next_w < end_w) begin
                cur_d = nl_next_w - AW'(col_q);
                col_d = '0;
              end
            end else if (char_q == CH_BACKSPACE) begin
              if (cur_q > base_w) begin
                cur_d       = cur_q - AW'(1);
                col_d       = (col_q == '0) ? CW'(SCREEN_COLS - 1) : col_q - CW'(1);
                cell_pend_d = 1'b1;
                cell_addr_d = cur_q - AW'(1);
                cell_char_d = CH_BLANK;
              end
            end else begin
              if (cur_q + AW'(1) < end_w) begin
                cur_d       = cur_q + AW'(1);
                col_d       = (col_q == CW'(SCREEN_COLS - 1)) ? '0 : col_q + CW'(1);
                cell_pend_d = 1'b1;
                cell_addr_d = cur_q;
                cell_char_d = char_q;
              end
            end
          end
          MODE_SCROLL_UP: begin
            if (view_q > base_w) view_d = view_q - AW'(SCREEN_COLS);
          end
          MODE_SCROLL_DOWN: begin
            if (scr_sum_w < end_w) view_d = view_q + AW'(SCREEN_COLS);
          end
          MODE_SELECT: ;
        endcase
      end
      S_SCROLL: begin
        if (step_en) view_d = view_q + AW'(SCREEN_COLS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vis_q   <= '0;
      attr_q  <= ATTR_RESET;
      for (int c = 0; c < CONSOLES; c++) begin
        cur_mem_q[c]  <= AW'(c * RegionSize);
        view_mem_q[c] <= AW'(c * RegionSize);
        col_mem_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) attr_q <= cfg_i.data;
      if (state_q == S_EXEC && mode_q == MODE_SELECT) vis_q <= con_q;
      if (wb_en) begin
        cur_mem_q[con_q]  <= cur_q;
        view_mem_q[con_q] <= view_q;
        col_mem_q[con_q]  <= col_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    view_q      <= view_d;
    col_q       <= col_d;
    cell_pend_q <= cell_pend_d;
    cell_addr_q <= cell_addr_d;
    cell_char_q <= cell_char_d;
    if (in_fire) begin
      mode_q <= mode_e'(in_i.mode);
      con_q  <= in_con_w;
      char_q <= in_i.char_code;
    end
    if (wb_en) disp_q <= disp_w;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input taken while a result is pending");

  a_cursor_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL) |-> (cur_q >= base_w) && (cur_q < end_w))
    else $error("cursor left its console region");

  a_cell_then_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL && out_fire && disp_q) |=> (state_q == S_DISP) && out_o.valid)
    else $error("display update lost after cell write");

  a_bad_console: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !con_ok) |=> (state_q == S_IDLE))
    else $error("out-of-range console started work");

  a_scroll_put_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL && mode_q != MODE_PUT) |=> (state_q != S_SCROLL))
    else $error("auto-scroll ran for a non-put item");

endmodule
